>>> src/gfir_pkg.sv
// ----------------------------------------------------------------------------
// gfir_pkg
// Types, constants and arithmetic helpers for the five-tap Gaussian smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package gfir_pkg;

   localparam int SAMPLE_W = 16;
   localparam int TAP_W    = 16;
   localparam int FRAC     = 14;
   localparam int RADIUS   = 2;
   localparam int WIN      = 2 * RADIUS;
   localparam int SEEN_W   = 3;
   localparam int PROD_W   = SAMPLE_W + TAP_W + 1;
   localparam int ACC_W    = PROD_W + 3;
   localparam int Q_W      = ACC_W - FRAC;
   localparam int IDX_W    = 2;

   localparam logic [TAP_W-1:0] TAP_CENTER_RST = 16'd13074;
   localparam logic [TAP_W-1:0] TAP_ONE_RST    = 16'd4810;
   localparam logic [TAP_W-1:0] TAP_TWO_RST    = 16'd240;

   localparam logic [IDX_W-1:0] REG_TAP_CENTER = 2'd0;
   localparam logic [IDX_W-1:0] REG_TAP_ONE    = 2'd1;
   localparam logic [IDX_W-1:0] REG_TAP_TWO    = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smoothed;
      logic                       last_out;
   } rsp_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctl_type;

   // Signed sample times unsigned Q2.14 weight.
   function automatic logic signed [PROD_W-1:0] mul_tap(
      input logic signed [SAMPLE_W-1:0] s,
      input logic        [TAP_W-1:0]    w
   );
      logic signed [PROD_W-1:0] p;
      p = s * $signed({1'b0, w});
      return p;
   endfunction

   function automatic logic signed [ACC_W-1:0] sext_prod(
      input logic signed [PROD_W-1:0] p
   );
      return {{(ACC_W - PROD_W){p[PROD_W-1]}}, p};
   endfunction

   // Round half up, floor shift, saturate to the sample range.
   function automatic logic signed [SAMPLE_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc
   );
      logic signed [ACC_W-1:0] biased;
      logic signed [Q_W-1:0]   q;
      logic signed [Q_W-1:0]   qmax;
      logic signed [Q_W-1:0]   qmin;
      biased = acc + (ACC_W'(1) <<< (FRAC - 1));
      q      = biased[ACC_W-1:FRAC];
      qmax   = Q_W'(32767);
      qmin   = -Q_W'(32768);
      if (q > qmax) begin
         return 16'sh7fff;
      end else if (q < qmin) begin
         return 16'sh8000;
      end
      return q[SAMPLE_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/gfir_cell.sv
// ----------------------------------------------------------------------------
// gfir_cell
// One history cell: holds a sample, hands it to its neighbor on shift, zeroes it
// on clear and forms the product of the held sample with its tap weight.
// ----------------------------------------------------------------------------
`default_nettype none

module gfir_cell
   import gfir_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cell_ctl_type               ctl,
   input  wire logic signed [SAMPLE_W-1:0] data_in,
   input  wire logic        [TAP_W-1:0]    weight,
   output      logic signed [SAMPLE_W-1:0] sample_out,
   output      logic signed [PROD_W-1:0]   prod_out
);

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] sample_in;

   always_comb begin
      sample_in = sample_ff;
      if (ctl.clear) begin
         sample_in = '0;
      end else if (ctl.shift) begin
         sample_in = data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;
   assign prod_out   = mul_tap(sample_ff, weight);

endmodule

`default_nettype wire

>>> src/gaussian_smoothing_fir.sv
// Path: an accepted item's products are registered in the job register, and
//   each of its results then passes through the output register onto rsp.
// Throughput: one sample per cycle while the output is not stalled; a sample
//   marked last yields up to three results through the single output register
//   and holds req_stall while they drain.
// Reset: synchronous; clears history, spectrum position, pending results and
//   the output valid flag, and loads the default tap weights.
// ----------------------------------------------------------------------------
// gaussian_smoothing_fir
// Streaming five-tap symmetric Gaussian smoother over a chain of history cells.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_smoothing_fir
   import gfir_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire req_type          req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      rsp_type          rsp_data,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [IDX_W-1:0] csr_index,
   input  wire logic [TAP_W-1:0] csr_data
);

   // configuration
   logic [TAP_W-1:0] tap_center_ff, tap_one_ff, tap_two_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_center_ff <= TAP_CENTER_RST;
         tap_one_ff    <= TAP_ONE_RST;
         tap_two_ff    <= TAP_TWO_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TAP_CENTER: tap_center_ff <= csr_data;
            REG_TAP_ONE:    tap_one_ff    <= csr_data;
            REG_TAP_TWO:    tap_two_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // history cell chain
   logic                       accept;
   cell_ctl_type               cell_ctl;
   logic signed [SAMPLE_W-1:0] hist [WIN];
   logic signed [PROD_W-1:0]   hprod [WIN];
   logic        [TAP_W-1:0]    cell_w [WIN];

   assign accept         = req_valid && !req_stall;
   assign cell_ctl.shift = accept && !req_data.last_in;
   assign cell_ctl.clear = accept && req_data.last_in;

   assign cell_w[0] = tap_one_ff;
   assign cell_w[1] = tap_center_ff;
   assign cell_w[2] = tap_one_ff;
   assign cell_w[3] = tap_two_ff;

   for (genvar i = 0; i < WIN; i++) begin : g_cell
      gfir_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .data_in    ((i == 0) ? req_data.sample : hist[(i == 0) ? 0 : i - 1]),
         .weight     (cell_w[i]),
         .sample_out (hist[i]),
         .prod_out   (hprod[i])
      );
   end

   // spectrum position, saturating at WIN
   logic [SEEN_W-1:0] seen_ff, seen_in;

   always_comb begin
      seen_in = seen_ff;
      if (accept) begin
         if (req_data.last_in) begin
            seen_in = '0;
         end else if (seen_ff < SEEN_W'(WIN)) begin
            seen_in = seen_ff + SEEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // job register: products and pass-through values of one accepted item
   logic                       job_valid_ff, job_valid_in;
   logic                       pend_a_ff, pend_b_ff, pend_c_ff;
   logic                       pend_a_in, pend_b_in, pend_c_in;
   logic                       smooth_ff;
   logic signed [PROD_W-1:0]   prod_ff [WIN+1];
   logic signed [SAMPLE_W-1:0] pass_a_ff, pass_b_ff, pass_c_ff;

   logic                       pend_any, out_free, emit, job_done;
   logic signed [ACC_W-1:0]    acc;
   rsp_type                    cur_item;

   assign pend_any = pend_a_ff || pend_b_ff || pend_c_ff;
   assign out_free = !rsp_valid || !rsp_stall;
   assign emit     = job_valid_ff && pend_any && out_free;

   assign acc = sext_prod(prod_ff[0]) + sext_prod(prod_ff[1]) + sext_prod(prod_ff[2])
              + sext_prod(prod_ff[3]) + sext_prod(prod_ff[4]);

   // first pending result goes next: smoothed/passed, then history, then last
   always_comb begin
      pend_a_in = pend_a_ff;
      pend_b_in = pend_b_ff;
      pend_c_in = pend_c_ff;
      cur_item  = '{smoothed: pass_c_ff, last_out: 1'b1};
      if (pend_a_ff) begin
         cur_item  = '{smoothed: (smooth_ff ? round_sat(acc) : pass_a_ff), last_out: 1'b0};
         pend_a_in = !emit;
      end else if (pend_b_ff) begin
         cur_item  = '{smoothed: pass_b_ff, last_out: 1'b0};
         pend_b_in = !emit;
      end else begin
         pend_c_in = pend_c_ff && !emit;
      end
   end

   assign job_done  = job_valid_ff && !(pend_a_in || pend_b_in || pend_c_in);
   assign req_stall = job_valid_ff && !job_done;

   always_comb begin
      job_valid_in = job_valid_ff;
      if (accept) begin
         job_valid_in = 1'b1;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         pend_a_ff    <= 1'b0;
         pend_b_ff    <= 1'b0;
         pend_c_ff    <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         if (accept) begin
            pend_a_ff <= seen_ff >= SEEN_W'(RADIUS);
            pend_b_ff <= req_data.last_in && (seen_ff != '0);
            pend_c_ff <= req_data.last_in;
         end else begin
            pend_a_ff <= pend_a_in;
            pend_b_ff <= pend_b_in;
            pend_c_ff <= pend_c_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         smooth_ff  <= seen_ff >= SEEN_W'(WIN);
         prod_ff[0] <= mul_tap(req_data.sample, tap_two_ff);
         for (int i = 0; i < WIN; i++) begin
            prod_ff[i+1] <= hprod[i];
         end
         pass_a_ff  <= hist[RADIUS-1];
         pass_b_ff  <= hist[0];
         pass_c_ff  <= req_data.sample;
      end
   end

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= cur_item;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= SEEN_W'(WIN))
      else $error("spectrum position out of range");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (job_valid_ff && pend_any))
      else $error("input stalled without pending results");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last_in) |=> (seen_ff == '0 && pend_c_ff))
      else $error("last item did not restart the spectrum");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted result not held in output register");

endmodule

`default_nettype wire

>>> tb/tb_gaussian_smoothing_fir.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_smoothing_fir
// Drives spectra of random and boundary flux samples through the five-tap
// smoother under random valid gaps and output stalls, predicts every result
// in-line from a cycle-free model of the filter and compares each one in order.
// ----------------------------------------------------------------------------

module tb_gaussian_smoothing_fir;
   import gfir_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_valid  = 1'b0;
   logic             req_stall;
   req_type          req_data   = '0;
   logic             rsp_valid;
   logic             rsp_stall  = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [IDX_W-1:0] csr_index  = '0;
   logic [TAP_W-1:0] csr_data   = '0;

   gaussian_smoothing_fir dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // filter state mirrored in the testbench
   logic [TAP_W-1:0]           w_center = TAP_CENTER_RST;
   logic [TAP_W-1:0]           w_one    = TAP_ONE_RST;
   logic [TAP_W-1:0]           w_two    = TAP_TWO_RST;
   logic signed [SAMPLE_W-1:0] flux_hist [WIN];
   int                         held_count = 0;
   rsp_type                    smoothed_due [$];

   int idle_pct      = 34;
   int items_sent    = 0;
   int spectra_sent  = 0;
   int results_seen  = 0;
   int tap_writes    = 0;
   int mismatches    = 0;
   int cycle_count   = 0;

   initial begin
      for (int i = 0; i < WIN; i++) begin
         flux_hist[i] = '0;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] weighed_sum(
      input logic signed [SAMPLE_W-1:0] newest
   );
      longint acc;
      longint q;
      acc = longint'(w_two) * (longint'(newest) + longint'(flux_hist[3]))
          + longint'(w_one) * (longint'(flux_hist[0]) + longint'(flux_hist[2]))
          + longint'(w_center) * longint'(flux_hist[1]);
      acc = acc + (longint'(1) <<< (FRAC - 1));
      q = acc >>> FRAC;
      if (q > 32767) begin
         q = 32767;
      end else if (q < -32768) begin
         q = -32768;
      end
      return q[SAMPLE_W-1:0];
   endfunction

   function automatic void push_due(input logic signed [SAMPLE_W-1:0] v, input logic last);
      rsp_type r;
      r.smoothed = v;
      r.last_out = last;
      smoothed_due.push_back(r);
   endfunction

   function automatic void predict_smoothing(
      input logic signed [SAMPLE_W-1:0] x,
      input logic                       last
   );
      if (held_count >= RADIUS) begin
         push_due((held_count >= WIN) ? weighed_sum(x) : flux_hist[RADIUS-1], 1'b0);
      end
      if (last) begin
         if (held_count >= 1) begin
            push_due(flux_hist[0], 1'b0);
         end
         push_due(x, 1'b1);
         for (int i = 0; i < WIN; i++) begin
            flux_hist[i] = '0;
         end
         held_count = 0;
      end else begin
         for (int i = WIN - 1; i > 0; i--) begin
            flux_hist[i] = flux_hist[i-1];
         end
         flux_hist[0] = x;
         if (held_count < WIN) begin
            held_count++;
         end
      end
   endfunction

   // output side: random stall, in-order compare
   always @(negedge clock) begin
      rsp_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (smoothed_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: unexpected result smoothed=%0d last_out=%0b",
                        rsp_data.smoothed, rsp_data.last_out);
            end
         end else begin
            want = smoothed_due.pop_front();
            if (rsp_data.smoothed !== want.smoothed || rsp_data.last_out !== want.last_out)
            begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("ERROR: result %0d expected smoothed=%0d last_out=%0b, got %0d %0b",
                           results_seen, want.smoothed, want.last_out,
                           rsp_data.smoothed, rsp_data.last_out);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ERROR: timeout with %0d results outstanding", smoothed_due.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // shared drivers
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
      @(negedge clock);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_data.sample  = s;
      req_data.last_in = last;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      predict_smoothing(s, last);
      items_sent++;
      if (last) begin
         spectra_sent++;
      end
   endtask

   // drop valid, let every due result arrive, then let the pipe settle
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (smoothed_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic write_tap(input logic [IDX_W-1:0] idx, input logic [TAP_W-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      case (idx)
         REG_TAP_CENTER: w_center = val;
         REG_TAP_ONE:    w_one    = val;
         REG_TAP_TWO:    w_two    = val;
         default: ;
      endcase
      tap_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic write_kernel(input logic [TAP_W-1:0] c, input logic [TAP_W-1:0] o,
                               input logic [TAP_W-1:0] t);
      write_tap(REG_TAP_CENTER, c);
      write_tap(REG_TAP_ONE, o);
      write_tap(REG_TAP_TWO, t);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] rand_flux();
      case ($urandom_range(9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2, 3:    return SAMPLE_W'($signed($urandom_range(128)) - 64);
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic int rand_length();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         return $urandom_range(10, 1);
      end else if (pick < 95) begin
         return $urandom_range(24, 11);
      end
      return $urandom_range(40, 25);
   endfunction

   task automatic send_spectrum(input int len);
      for (int i = 0; i < len; i++) begin
         send_sample(rand_flux(), i == len - 1);
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // default kernel: spectra of one to five samples, negative saturation
   task automatic test_short_spectra();
      send_sample(16'sh8000, 1'b1);
      send_sample(16'sh7fff, 1'b0);
      send_sample(-16'sd1, 1'b1);
      send_sample(16'sd0, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(-16'sd1, 1'b1);
      send_spectrum(4);
      for (int i = 0; i < 5; i++) begin
         send_sample(16'sh8000, i == 4);
      end
      wait_drained();
   endtask

   // zero and full-scale weights, plus a write to the unused index
   task automatic test_tap_extremes();
      write_kernel(16'hffff, 16'hffff, 16'hffff);
      write_tap(2'd3, 16'h5a5a);
      for (int i = 0; i < 6; i++) begin
         send_sample(16'sh7fff, i == 5);
      end
      wait_drained();
      write_kernel(16'h0000, 16'h0000, 16'h0000);
      send_spectrum(5);
      wait_drained();
   endtask

   // hold the sender mid-spectrum until the output side is empty
   task automatic test_pause_drain();
      write_kernel(TAP_CENTER_RST, TAP_ONE_RST, TAP_TWO_RST);
      for (int n = 0; n < 2; n++) begin
         int len;
         int hold_at;
         len     = $urandom_range(12, 6);
         hold_at = $urandom_range(len - 2, 1);
         for (int i = 0; i < len; i++) begin
            if (i == hold_at) begin
               wait_drained();
            end
            send_sample(rand_flux(), i == len - 1);
         end
      end
      wait_drained();
   endtask

   // random kernels and random spectra under random gaps and stalls
   task automatic test_random_spectra(input int target);
      int start;
      int since_cfg;
      start     = items_sent;
      since_cfg = 0;
      while (items_sent - start < target) begin
         if (since_cfg >= $urandom_range(8, 3)) begin
            wait_drained();
            case ($urandom_range(3))
               0: write_kernel(16'hffff, 16'h0000, 16'hffff);
               1: write_kernel(TAP_W'($urandom_range(16384, 4096)),
                               TAP_W'($urandom_range(6000)),
                               TAP_W'($urandom_range(1500)));
               default: write_tap(IDX_W'($urandom_range(3)),
                                  TAP_W'($urandom_range(65535)));
            endcase
            since_cfg = 0;
         end
         send_spectrum(rand_length());
         since_cfg++;
      end
      wait_drained();
   endtask

   // back-to-back items with the output never stalled
   task automatic test_no_idle_stretch();
      idle_pct = 0;
      write_kernel(TAP_W'($urandom_range(65535)), TAP_W'($urandom_range(65535)),
                   TAP_W'($urandom_range(65535)));
      send_spectrum(30);
      send_spectrum(1);
      send_spectrum(2);
      send_spectrum(27);
      wait_drained();
      idle_pct = 34;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_short_spectra();
      test_tap_extremes();
      test_pause_drain();
      test_random_spectra(200);
      test_no_idle_stretch();

      while (smoothed_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Ran %0d spectra (%0d samples, %0d results) over %0d tap writes,",
               spectra_sent, items_sent, results_seen, tap_writes);
      $display("covering short spectra, zero and full-scale weights, drain pauses and stalls.");
      if (mismatches == 0 && smoothed_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("ERROR: %0d mismatches, %0d results missing", mismatches, smoothed_due.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> sim.f
src/gfir_pkg.sv
src/gfir_cell.sv
src/gaussian_smoothing_fir.sv
tb/tb_gaussian_smoothing_fir.sv
